// ===== hdl/magnetometer_heading_angle_defines.svh =====
// Assertion macros for the magnetometer heading angle block
`ifndef MAGNETOMETER_HEADING_ANGLE_DEFINES_SVH
`define MAGNETOMETER_HEADING_ANGLE_DEFINES_SVH

// Check prop on every rising edge outside reset
`define HMH_ASSERT_CK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond on one edge is followed by res on the next edge
`define HMH_ASSERT_NEXT(lbl, ck, rst_n, cond, res, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

// ===== hdl/hmh_pkg.sv =====
// Shared types, constants and arctangent table for the heading angle pipeline
`default_nettype none
package hmh_pkg;

	localparam int VEC_W     = 28;
	localparam int ANG_W     = 32;
	localparam int SAMPLE_W  = 16;
	localparam int HEAD_W    = 16;
	localparam int TAB_LEN   = 24;
	localparam int FRAC_BITS = 16;

	localparam logic signed [ANG_W-1:0] HALF_TURN    = 32'sd1179648000;
	localparam logic signed [ANG_W-1:0] NEG_HALF_TURN = -32'sd1179648000;
	localparam logic [HEAD_W-1:0]       ZERO_HEADING = 16'd18000;
	localparam logic [HEAD_W-1:0]       MAX_HEADING  = 16'd36000;
	// half turn plus half of one output step
	localparam logic signed [ANG_W+1:0] ROUND_OFFSET = 34'sd1179680768;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
		32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
		32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
		32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
		32'sd358,       32'sd179,       32'sd90,       32'sd45
	};

	typedef struct packed {
		logic                    zero;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} hmh_vec_t;

endpackage
`default_nettype wire

// ===== hdl/hmh_prerot.sv =====
// Input stage: zero detect, half-turn pre-rotation and scaling of the sample
`default_nettype none
module hmh_prerot (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [hmh_pkg::SAMPLE_W-1:0] in_x,
	input  wire logic signed [hmh_pkg::SAMPLE_W-1:0] in_y,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output hmh_pkg::hmh_vec_t                    out_vec
);
	import hmh_pkg::*;

	logic                      vld_s1;
	hmh_vec_t                  vec_s1;
	hmh_vec_t                  vec_d;
	logic signed [SAMPLE_W:0]  x_ext;
	logic signed [SAMPLE_W:0]  y_ext;
	logic signed [SAMPLE_W:0]  x_rot;
	logic signed [SAMPLE_W:0]  y_rot;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_vec   = vec_s1;

	always_comb begin
		x_ext      = {in_x[SAMPLE_W-1], in_x};
		y_ext      = {in_y[SAMPLE_W-1], in_y};
		x_rot      = in_x[SAMPLE_W-1] ? -x_ext : x_ext;
		y_rot      = in_x[SAMPLE_W-1] ? -y_ext : y_ext;
		vec_d.zero = (in_x == '0) && (in_y == '0);
		vec_d.x    = {{(VEC_W-SAMPLE_W-9){x_rot[SAMPLE_W]}}, x_rot, 8'd0};
		vec_d.y    = {{(VEC_W-SAMPLE_W-9){y_rot[SAMPLE_W]}}, y_rot, 8'd0};
		if (!in_x[SAMPLE_W-1]) begin
			vec_d.z = '0;
		end else if (!in_y[SAMPLE_W-1]) begin
			vec_d.z = HALF_TURN;
		end else begin
			vec_d.z = NEG_HALF_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vec_s1 <= vec_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hmh_rot_stage.sv =====
// One vectoring micro-rotation stage of the angle pipeline
`default_nettype none
module hmh_rot_stage #(
	parameter int STAGE = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire hmh_pkg::hmh_vec_t in_vec,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hmh_pkg::hmh_vec_t      out_vec
);
	import hmh_pkg::*;

	logic                    vld_s2;
	hmh_vec_t                vec_s2;
	hmh_vec_t                vec_d;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic                    y_pos;

	assign in_ready  = !vld_s2 || out_ready;
	assign out_valid = vld_s2;
	assign out_vec   = vec_s2;

	always_comb begin
		dx         = in_vec.y >>> STAGE;
		dy         = in_vec.x >>> STAGE;
		y_pos      = !in_vec.y[VEC_W-1] && (in_vec.y != '0);
		vec_d.zero = in_vec.zero;
		if (y_pos) begin
			vec_d.x = in_vec.x + dx;
			vec_d.y = in_vec.y - dy;
			vec_d.z = in_vec.z + ATAN_TAB[STAGE];
		end else begin
			vec_d.x = in_vec.x - dx;
			vec_d.y = in_vec.y + dy;
			vec_d.z = in_vec.z - ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vec_s2 <= vec_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hmh_post.sv =====
// Output stage: offset, round and clamp the angle to hundredths of a degree
`default_nettype none
`include "magnetometer_heading_angle_defines.svh"
module hmh_post (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire hmh_pkg::hmh_vec_t            in_vec,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [hmh_pkg::HEAD_W-1:0]        out_heading
);
	import hmh_pkg::*;

	logic                    vld_s3;
	logic [HEAD_W-1:0]       heading_s3;
	logic [HEAD_W-1:0]       heading_d;
	logic signed [ANG_W+1:0] h_sum;
	logic [ANG_W+1-FRAC_BITS:0] h_int;

	assign in_ready    = !vld_s3 || out_ready;
	assign out_valid   = vld_s3;
	assign out_heading = heading_s3;

	always_comb begin
		h_sum = {{2{in_vec.z[ANG_W-1]}}, in_vec.z} + ROUND_OFFSET;
		h_int = h_sum[ANG_W+1:FRAC_BITS];
		if (in_vec.zero) begin
			heading_d = ZERO_HEADING;
		end else if (h_sum[ANG_W+1]) begin
			heading_d = '0;
		end else if (h_int > {{(ANG_W+2-FRAC_BITS-HEAD_W){1'b0}}, MAX_HEADING}) begin
			heading_d = MAX_HEADING;
		end else begin
			heading_d = h_int[HEAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			heading_s3 <= heading_d;
		end
	end

	`HMH_ASSERT_CK(a_heading_range, clk, arst_n, !vld_s3 || (heading_s3 <= MAX_HEADING), "heading out of range")
	`HMH_ASSERT_NEXT(a_zero_heading, clk, arst_n, in_valid && in_ready && in_vec.zero, heading_s3 == ZERO_HEADING, "zero sample heading wrong")
	`HMH_ASSERT_NEXT(a_load_valid, clk, arst_n, in_valid && in_ready, vld_s3, "transfer into output stage lost")

endmodule
`default_nettype wire

// ===== hdl/magnetometer_heading_angle.sv =====
// Top level: pipelined vectoring atan2 compass heading from X/Y magnetometer readings
//
//   channel  | dir | fields
//   s_*      | in  | tdata[15:0] mag_x, tdata[31:16] mag_y (signed)
//   m_*      | out | tdata[15:0] heading_centideg, 0..36000
//
// The pipeline has one pre-rotation stage, one stage per micro-rotation and one
// rounding stage. One sample enters per cycle unless m_tready stalls the pipeline.
// Reset clears only the stage valid bits.
// Each stage has its own ready, so bubbles fill while m_tready is low and a stall
// holds every stage without loss.
`default_nettype none
module magnetometer_heading_angle #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // mag_x [15:0], mag_y [31:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // heading_centideg [15:0]
);
	import hmh_pkg::*;

	localparam int NITER = (ANGLE_ITERATIONS > TAB_LEN) ? TAB_LEN : ANGLE_ITERATIONS;

	hmh_vec_t vec   [NITER+1];
	logic     valid [NITER+1];
	logic     ready [NITER+1];

	hmh_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      (s_tdata[SAMPLE_W-1:0]),
		.in_y      (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_vec   (vec[0])
	);

	for (genvar i = 0; i < NITER; i++) begin : g_rot
		hmh_rot_stage #(
			.STAGE (i)
		) u_rot (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_vec    (vec[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_vec   (vec[i+1])
		);
	end

	hmh_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid[NITER]),
		.in_ready    (ready[NITER]),
		.in_vec      (vec[NITER]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_heading (m_tdata)
	);

endmodule
`default_nettype wire
